// ===== design/fcdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fcdl_pkg
// Event, status and register index codes of the fault channel debounce logger.
// ----------------------------------------------------------------------------
`default_nettype none

package fcdl_pkg;

  // event kinds carried by op and by log_event
  localparam logic [1:0] OP_OK    = 2'd0;
  localparam logic [1:0] OP_FAULT = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // status codes of a result
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_ERROR     = 3'd1;
  localparam logic [2:0] STAT_WARNING   = 3'd2;
  localparam logic [2:0] STAT_WRONG_ID  = 3'd3;
  localparam logic [2:0] STAT_INVALID   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_RECORDING = 3'd1;
  localparam logic [2:0] CFG_RESERVED  = 3'd2;
  localparam logic [2:0] CFG_THR_A     = 3'd3;
  localparam logic [2:0] CFG_THR_B     = 3'd4;
  localparam logic [2:0] CFG_THR_C     = 3'd5;
  localparam logic [2:0] CFG_THR_D     = 3'd6;
  localparam logic [2:0] CFG_LOG_CAP   = 3'd7;

  // register reset values
  localparam logic [31:0] ENABLE_RESET  = 32'hFFFF_FFFF;
  localparam logic [7:0]  LOG_CAP_RESET = 8'd8;

endpackage

`default_nettype wire

// ===== design/fault_channel_debounce_logger_core.sv =====
// ----------------------------------------------------------------------------
// fault_channel_debounce_logger_core
// Per-channel fault debounce counters with flags, notifications and a
// filtered log record stream.
// ----------------------------------------------------------------------------
// An event is taken at every clock edge with start high (busy stays low), so
// one event per cycle is sustained. The event is registered at that edge, one
// pass of logic updates the addressed channel's counter, flags and log state
// and loads the result register at the next edge; done is registered at that
// same edge. The receiver cannot stall: each result is shown for exactly one
// cycle. Back-to-back events on the same channel see each other's updates,
// since the channel state is written at the same edge as the result.
// Configuration writes take effect at the next edge and are meant for idle
// periods only.
`default_nettype none

module fault_channel_debounce_logger_core #(
  parameter int CHANNEL_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // event command
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  channel,
  input  wire logic [31:0] item_number,
  input  wire logic [31:0] time_stamp,
  // configuration write port
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data,
  // result
  output logic             done,
  output logic [2:0]       status,
  output logic             error_flag,
  output logic             warning_flag,
  output logic             notify_valid,
  output logic             notify_kind,
  output logic             log_valid,
  output logic [4:0]       log_channel,
  output logic [1:0]       log_event,
  output logic [31:0]      log_item,
  output logic [31:0]      log_time,
  output logic [31:0]      log_total
);

  localparam int         CH_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [6:0] CH_LIMIT = 7'(CHANNEL_COUNT);

  // configuration registers
  logic [31:0] enable_mask;
  logic [31:0] recording_mask;
  logic [31:0] reserved_mask;
  logic [63:0] thr_word [4];
  logic [7:0]  log_cap;

  // channel state
  logic [8:0]  occ_count  [CHANNEL_COUNT];
  logic        err_flags  [CHANNEL_COUNT];
  logic        warn_flags [CHANNEL_COUNT];
  logic [1:0]  last_event [CHANNEL_COUNT];
  logic [7:0]  log_count  [CHANNEL_COUNT];
  logic [31:0] total_records;

  // input register
  logic        in_vld;
  logic [1:0]  in_op;
  logic [5:0]  in_channel;
  logic [31:0] in_item;
  logic [31:0] in_time;

  // working values
  logic [CH_W-1:0] idx;
  logic [4:0]      mb;
  logic            id_ok;
  logic            upd;
  logic            enabled;
  logic            recording;
  logic [8:0]      thr;
  logic [8:0]      cnt_cur;
  logic            err_cur;
  logic            warn_cur;
  logic [1:0]      last_cur;
  logic [7:0]      lcnt_cur;
  logic [8:0]      cnt_next;
  logic            err_next;
  logic            warn_next;
  logic [1:0]      last_next;
  logic [7:0]      lcnt_next;
  logic [31:0]     total_next;
  logic [2:0]      res_status;
  logic            res_notify;
  logic            res_kind;
  logic            log_req;
  logic [1:0]      log_ev;
  logic            log_pass;

  assign busy = 1'b0;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= fcdl_pkg::ENABLE_RESET;
      recording_mask <= '0;
      reserved_mask  <= '0;
      for (int i = 0; i < 4; i++) begin
        thr_word[i] <= '0;
      end
      log_cap        <= fcdl_pkg::LOG_CAP_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        fcdl_pkg::CFG_ENABLE:    enable_mask    <= wr_data[31:0];
        fcdl_pkg::CFG_RECORDING: recording_mask <= wr_data[31:0];
        fcdl_pkg::CFG_RESERVED:  reserved_mask  <= wr_data[31:0];
        fcdl_pkg::CFG_THR_A:     thr_word[0]    <= wr_data;
        fcdl_pkg::CFG_THR_B:     thr_word[1]    <= wr_data;
        fcdl_pkg::CFG_THR_C:     thr_word[2]    <= wr_data;
        fcdl_pkg::CFG_THR_D:     thr_word[3]    <= wr_data;
        fcdl_pkg::CFG_LOG_CAP:   log_cap        <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // register the event on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op      <= op;
      in_channel <= channel;
      in_item    <= item_number;
      in_time    <= time_stamp;
    end
  end

  // look up the addressed channel
  always_comb begin
    idx       = in_channel[CH_W-1:0];
    mb        = in_channel[4:0];
    id_ok     = {1'b0, in_channel} < CH_LIMIT;
    upd       = id_ok && !reserved_mask[mb];
    enabled   = enable_mask[mb];
    recording = recording_mask[mb];
    thr       = {1'b0, thr_word[in_channel[4:3]][{in_channel[2:0], 3'b000} +: 8]};
    cnt_cur   = occ_count[idx];
    err_cur   = err_flags[idx];
    warn_cur  = warn_flags[idx];
    last_cur  = last_event[idx];
    lcnt_cur  = log_count[idx];
  end

  // debounce the event
  always_comb begin
    cnt_next   = cnt_cur;
    err_next   = err_cur;
    warn_next  = warn_cur;
    res_status = fcdl_pkg::STAT_OK;
    res_notify = 1'b0;
    res_kind   = 1'b0;
    log_req    = 1'b0;
    log_ev     = fcdl_pkg::OP_OK;
    priority if (!id_ok) begin
      res_status = fcdl_pkg::STAT_WRONG_ID;
    end else if (!upd) begin
      res_status = fcdl_pkg::STAT_INVALID;
    end else begin
      unique case (in_op)
        fcdl_pkg::OP_OK: begin
          if (enabled) begin
            priority if (cnt_cur > 9'd1) begin
              cnt_next = cnt_cur - 9'd1;
            end else if (cnt_cur == 9'd1) begin
              cnt_next   = '0;
              err_next   = 1'b0;
              warn_next  = 1'b0;
              log_req    = recording;
              log_ev     = fcdl_pkg::OP_OK;
              res_notify = 1'b1;
              res_kind   = 1'b1;
            end else begin
              cnt_next = cnt_cur;
            end
          end
        end
        fcdl_pkg::OP_FAULT: begin
          if (enabled) begin
            priority if (cnt_cur < thr) begin
              cnt_next = cnt_cur + 9'd1;
            end else if (cnt_cur == thr) begin
              cnt_next   = cnt_cur + 9'd1;
              err_next   = 1'b1;
              warn_next  = 1'b0;
              log_req    = recording;
              log_ev     = fcdl_pkg::OP_FAULT;
              res_notify = 1'b1;
              res_status = fcdl_pkg::STAT_ERROR;
            end else begin
              res_status = fcdl_pkg::STAT_ERROR;
            end
          end else begin
            err_next   = 1'b0;
            warn_next  = 1'b1;
            res_status = fcdl_pkg::STAT_WARNING;
          end
        end
        fcdl_pkg::OP_RESET: begin
          if (enabled) begin
            cnt_next  = '0;
            err_next  = 1'b0;
            warn_next = 1'b0;
            log_req   = recording;
            log_ev    = fcdl_pkg::OP_RESET;
          end
        end
        default: ;
      endcase
    end
  end

  // filter the log request: drop repeats, reset after ok, and past the cap
  always_comb begin
    log_pass   = 1'b0;
    lcnt_next  = lcnt_cur;
    last_next  = last_cur;
    total_next = total_records;
    if (log_req) begin
      priority if (last_cur == log_ev) begin
        log_pass = 1'b0;
      end else if (last_cur == fcdl_pkg::OP_OK && log_ev == fcdl_pkg::OP_RESET) begin
        log_pass = 1'b0;
      end else if (lcnt_cur >= log_cap) begin
        lcnt_next = log_cap;
      end else begin
        log_pass   = 1'b1;
        lcnt_next  = lcnt_cur + 8'd1;
        total_next = total_records + 32'd1;
        last_next  = log_ev;
      end
    end
  end

  // write back channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        occ_count[i]  <= '0;
        err_flags[i]  <= 1'b0;
        warn_flags[i] <= 1'b0;
        last_event[i] <= fcdl_pkg::OP_OK;
        log_count[i]  <= '0;
      end
      total_records <= '0;
    end else if (in_vld && upd) begin
      occ_count[idx]  <= cnt_next;
      err_flags[idx]  <= err_next;
      warn_flags[idx] <= warn_next;
      last_event[idx] <= last_next;
      log_count[idx]  <= lcnt_next;
      total_records   <= total_next;
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      status       <= res_status;
      error_flag   <= upd ? err_next : 1'b0;
      warning_flag <= upd ? warn_next : 1'b0;
      notify_valid <= upd && res_notify;
      notify_kind  <= upd && res_kind;
      log_valid    <= upd && log_pass;
      log_channel  <= (upd && log_pass) ? in_channel[4:0] : '0;
      log_event    <= (upd && log_pass) ? log_ev : '0;
      log_item     <= (upd && log_pass) ? in_item : '0;
      log_time     <= (upd && log_pass) ? in_time : '0;
      log_total    <= (upd && log_pass) ? total_next : '0;
    end
  end

`ifndef SYNTH
  // every registered event yields one result in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_vld |=> done)
    else $error("result strobe missing after a registered event");

  // an emitted record carries the running total just stored
  a_log_total: assert property (@(posedge clk) disable iff (rst)
    (done && log_valid) |-> (log_total == total_records))
    else $error("log total out of step with the record counter");

  // a rejected channel id reports nothing else
  a_wrong_id: assert property (@(posedge clk) disable iff (rst)
    (done && status == fcdl_pkg::STAT_WRONG_ID) |->
      (!error_flag && !warning_flag && !notify_valid && !log_valid))
    else $error("wrong id result carries channel data");

  // an error set notification comes with the error flag raised
  a_notify_set: assert property (@(posedge clk) disable iff (rst)
    (done && notify_valid && !notify_kind) |-> (error_flag && !warning_flag))
    else $error("error set notification without error flag");

  // an error reset notification comes with both flags cleared
  a_notify_clear: assert property (@(posedge clk) disable iff (rst)
    (done && notify_valid && notify_kind) |-> (!error_flag && !warning_flag))
    else $error("error reset notification with a flag still set");
`endif

endmodule

`default_nettype wire

// ===== test/fcdl_checker.sv =====
// ----------------------------------------------------------------------------
// fcdl_checker
// Watches the event, configuration and result ports of the fault channel
// debounce logger. Keeps its own copy of the channel counters, flags and log
// filter state, predicts one result per accepted event and compares each
// result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdl_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  channel,
  input  wire logic [31:0] item_number,
  input  wire logic [31:0] time_stamp,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data,
  input  wire logic        done,
  input  wire logic [2:0]  status,
  input  wire logic        error_flag,
  input  wire logic        warning_flag,
  input  wire logic        notify_valid,
  input  wire logic        notify_kind,
  input  wire logic        log_valid,
  input  wire logic [4:0]  log_channel,
  input  wire logic [1:0]  log_event,
  input  wire logic [31:0] log_item,
  input  wire logic [31:0] log_time,
  input  wire logic [31:0] log_total,
  output int               mismatch_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CHANNELS = 32;

  // notification kinds
  localparam logic NOTE_ERR_SET   = 1'b0;
  localparam logic NOTE_ERR_CLEAR = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic        err;
    logic        warn;
    logic        note_valid;
    logic        note_kind;
    logic        log_valid;
    logic [4:0]  log_chan;
    logic [1:0]  log_ev;
    logic [31:0] log_item;
    logic [31:0] log_time;
    logic [31:0] log_total;
  } outcome_t;

  // register copies
  logic [31:0] cfg_enable;
  logic [31:0] cfg_recording;
  logic [31:0] cfg_reserved;
  logic [63:0] thr_word [4];
  logic [7:0]  cfg_log_cap;

  // channel state
  logic [8:0]  fault_count [NUM_CHANNELS];
  logic        err_state   [NUM_CHANNELS];
  logic        warn_state  [NUM_CHANNELS];
  logic [1:0]  last_logged [NUM_CHANNELS];
  logic [7:0]  log_tally   [NUM_CHANNELS];
  logic [31:0] records_total;

  outcome_t expected_q[$];

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Log filter: drop repeats, reset after ok, and records past the cap.
  function automatic void log_gate(int c, logic [1:0] ev, logic [31:0] item,
                                   logic [31:0] stamp, inout outcome_t r);
    if (last_logged[c] == ev)
      return;
    if (last_logged[c] == fcdl_pkg::OP_OK && ev == fcdl_pkg::OP_RESET)
      return;
    if (log_tally[c] >= cfg_log_cap) begin
      log_tally[c] = cfg_log_cap;
      return;
    end
    log_tally[c]   = log_tally[c] + 8'd1;
    records_total  = records_total + 32'd1;
    last_logged[c] = ev;
    r.log_valid = 1'b1;
    r.log_chan  = c[4:0];
    r.log_ev    = ev;
    r.log_item  = item;
    r.log_time  = stamp;
    r.log_total = records_total;
  endfunction

  // Advance the channel state for one event and return its result.
  function automatic outcome_t predict_event(logic [1:0] kind, logic [5:0] ch_id,
                                             logic [31:0] item, logic [31:0] stamp);
    outcome_t r;
    int c;
    logic [7:0] thr;
    logic en;
    logic rec;
    r = '0;
    if (ch_id >= NUM_CHANNELS) begin
      r.status = fcdl_pkg::STAT_WRONG_ID;
      return r;
    end
    c = int'(ch_id);
    if (cfg_reserved[c]) begin
      r.status = fcdl_pkg::STAT_INVALID;
      return r;
    end
    en  = cfg_enable[c];
    rec = cfg_recording[c];
    thr = thr_word[c / 8][(c % 8) * 8 +: 8];
    r.status = fcdl_pkg::STAT_OK;
    case (kind)
      fcdl_pkg::OP_OK: begin
        if (en) begin
          if (fault_count[c] > 9'd1) begin
            fault_count[c] = fault_count[c] - 9'd1;
          end else if (fault_count[c] == 9'd1) begin
            fault_count[c] = '0;
            err_state[c]   = 1'b0;
            warn_state[c]  = 1'b0;
            if (rec)
              log_gate(c, fcdl_pkg::OP_OK, item, stamp, r);
            r.note_valid = 1'b1;
            r.note_kind  = NOTE_ERR_CLEAR;
          end
        end
      end
      fcdl_pkg::OP_FAULT: begin
        if (!en) begin
          err_state[c]  = 1'b0;
          warn_state[c] = 1'b1;
          r.status      = fcdl_pkg::STAT_WARNING;
        end else if (fault_count[c] < {1'b0, thr}) begin
          fault_count[c] = fault_count[c] + 9'd1;
        end else if (fault_count[c] == {1'b0, thr}) begin
          fault_count[c] = fault_count[c] + 9'd1;
          err_state[c]   = 1'b1;
          warn_state[c]  = 1'b0;
          if (rec)
            log_gate(c, fcdl_pkg::OP_FAULT, item, stamp, r);
          r.note_valid = 1'b1;
          r.note_kind  = NOTE_ERR_SET;
          r.status     = fcdl_pkg::STAT_ERROR;
        end else begin
          r.status = fcdl_pkg::STAT_ERROR;
        end
      end
      fcdl_pkg::OP_RESET: begin
        if (en) begin
          err_state[c]   = 1'b0;
          warn_state[c]  = 1'b0;
          fault_count[c] = '0;
          if (rec)
            log_gate(c, fcdl_pkg::OP_RESET, item, stamp, r);
        end
      end
      default: ;
    endcase
    r.err  = err_state[c];
    r.warn = warn_state[c];
    return r;
  endfunction

  task automatic compare_result(outcome_t want);
    check_field("status", 32'(status), 32'(want.status));
    check_field("error_flag", 32'(error_flag), 32'(want.err));
    check_field("warning_flag", 32'(warning_flag), 32'(want.warn));
    check_field("notify_valid", 32'(notify_valid), 32'(want.note_valid));
    check_field("notify_kind", 32'(notify_kind), 32'(want.note_kind));
    check_field("log_valid", 32'(log_valid), 32'(want.log_valid));
    check_field("log_channel", 32'(log_channel), 32'(want.log_chan));
    check_field("log_event", 32'(log_event), 32'(want.log_ev));
    check_field("log_item", log_item, want.log_item);
    check_field("log_time", log_time, want.log_time);
    check_field("log_total", log_total, want.log_total);
  endtask

  // Compare first, then apply writes, then predict the new transfer.
  always @(posedge clk) begin
    if (rst) begin
      cfg_enable    = fcdl_pkg::ENABLE_RESET;
      cfg_recording = '0;
      cfg_reserved  = '0;
      cfg_log_cap   = fcdl_pkg::LOG_CAP_RESET;
      for (int i = 0; i < 4; i++)
        thr_word[i] = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        fault_count[i] = '0;
        err_state[i]   = 1'b0;
        warn_state[i]  = 1'b0;
        last_logged[i] = fcdl_pkg::OP_OK;
        log_tally[i]   = '0;
      end
      records_total = '0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0)
          report_mismatch("result strobe with no event outstanding");
        else
          compare_result(expected_q.pop_front());
      end
      if (wr_en) begin
        case (wr_index)
          fcdl_pkg::CFG_ENABLE:    cfg_enable    = wr_data[31:0];
          fcdl_pkg::CFG_RECORDING: cfg_recording = wr_data[31:0];
          fcdl_pkg::CFG_RESERVED:  cfg_reserved  = wr_data[31:0];
          fcdl_pkg::CFG_THR_A:     thr_word[0]   = wr_data;
          fcdl_pkg::CFG_THR_B:     thr_word[1]   = wr_data;
          fcdl_pkg::CFG_THR_C:     thr_word[2]   = wr_data;
          fcdl_pkg::CFG_THR_D:     thr_word[3]   = wr_data;
          fcdl_pkg::CFG_LOG_CAP:   cfg_log_cap   = wr_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_q.push_back(predict_event(op, channel, item_number, time_stamp));
    end
    outstanding = expected_q.size();
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the fault channel debounce logger with a directed event sequence,
// then phases of random events under different register settings, with random
// idle bursts. The checker beside the block predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         SETTLE    = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [5:0]  channel;
  logic [31:0] item_number;
  logic [31:0] time_stamp;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [63:0] wr_data;
  logic        done;
  logic [2:0]  status;
  logic        error_flag;
  logic        warning_flag;
  logic        notify_valid;
  logic        notify_kind;
  logic        log_valid;
  logic [4:0]  log_channel;
  logic [1:0]  log_event;
  logic [31:0] log_item;
  logic [31:0] log_time;
  logic [31:0] log_total;
  int          mismatch_count;
  int          outstanding;

  fault_channel_debounce_logger_core dut (
    .clk, .rst, .start, .busy, .op, .channel, .item_number, .time_stamp,
    .wr_en, .wr_index, .wr_data, .done, .status, .error_flag, .warning_flag,
    .notify_valid, .notify_kind, .log_valid, .log_channel, .log_event,
    .log_item, .log_time, .log_total
  );

  fcdl_checker chk (
    .clk, .rst, .start, .busy, .op, .channel, .item_number, .time_stamp,
    .wr_en, .wr_index, .wr_data, .done, .status, .error_flag, .warning_flag,
    .notify_valid, .notify_kind, .log_valid, .log_channel, .log_event,
    .log_item, .log_time, .log_total, .mismatch_count, .outstanding
  );

  always #10 clk = ~clk;

  // Hold start low and let the block drain before touching registers.
  task automatic wait_idle();
    start = 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
  endtask

  task automatic program_regs(logic [31:0] en, logic [31:0] rec, logic [31:0] res,
                              logic [63:0] ta, logic [63:0] tb, logic [63:0] tc,
                              logic [63:0] td, logic [7:0] cap);
    write_reg(fcdl_pkg::CFG_ENABLE, {32'h0, en});
    write_reg(fcdl_pkg::CFG_RECORDING, {32'h0, rec});
    write_reg(fcdl_pkg::CFG_RESERVED, {32'h0, res});
    write_reg(fcdl_pkg::CFG_THR_A, ta);
    write_reg(fcdl_pkg::CFG_THR_B, tb);
    write_reg(fcdl_pkg::CFG_THR_C, tc);
    write_reg(fcdl_pkg::CFG_THR_D, td);
    write_reg(fcdl_pkg::CFG_LOG_CAP, {56'h0, cap});
    wr_en = 1'b0;
  endtask

  // Present one event and hold it until the transfer; start stays high.
  task automatic send_event(logic [1:0] kind, logic [5:0] ch_id,
                            logic [31:0] item, logic [31:0] stamp);
    start       = 1'b1;
    op          = kind;
    channel     = ch_id;
    item_number = item;
    time_stamp  = stamp;
    do
      @(posedge clk);
    while (busy);
    @(negedge clk);
  endtask

  // Drop start for a burst and scramble the idle fields.
  task automatic maybe_idle(int gap_odds);
    int n;
    if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      n           = $urandom_range(1, 16);
      start       = 1'b0;
      op          = 2'($urandom);
      channel     = 6'($urandom);
      item_number = $urandom;
      time_stamp  = $urandom;
      repeat (n) @(negedge clk);
    end
  endtask

  // Mostly small thresholds so counters reach them, now and then a large one.
  function automatic logic [63:0] rand_thr_word();
    logic [63:0] w;
    for (int b = 0; b < 8; b++)
      w[b * 8 +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 3));
    return w;
  endfunction

  function automatic logic [7:0] rand_cap();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd5;
      4: return 8'd255;
      5: return 8'($urandom);
      default: return fcdl_pkg::LOG_CAP_RESET;
    endcase
  endfunction

  // Random events focused on a few neighboring channels.
  task automatic random_events(int n, int gap_odds);
    int base;
    int r;
    logic [1:0] kind;
    logic [5:0] ch_id;
    base = $urandom_range(0, 28);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0)
        base = $urandom_range(0, 28);
      r = $urandom_range(0, 99);
      if (r < 86)
        ch_id = 6'(base + $urandom_range(0, 3));
      else if (r < 95)
        ch_id = 6'($urandom_range(0, 31));
      else
        ch_id = 6'($urandom_range(32, 63));
      r = $urandom_range(0, 99);
      if (r < 45)
        kind = fcdl_pkg::OP_FAULT;
      else if (r < 80)
        kind = fcdl_pkg::OP_OK;
      else if (r < 96)
        kind = fcdl_pkg::OP_RESET;
      else
        kind = OP_UNUSED;
      send_event(kind, ch_id, $urandom, $urandom);
      maybe_idle(gap_odds);
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    op          = fcdl_pkg::OP_OK;
    channel     = '0;
    item_number = '0;
    time_stamp  = '0;
    wr_en       = 1'b0;
    wr_index    = fcdl_pkg::CFG_ENABLE;
    wr_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: ch0 threshold 2, ch1 threshold 0, ch2 threshold 1,
    // ch5 reserved, ch6 disabled
    program_regs(~32'h40, 32'hFFFF_FFFF, 32'h20, 64'h0000_0000_0001_0002,
                 64'h0, 64'h0, 64'h0, fcdl_pkg::LOG_CAP_RESET);
    send_event(fcdl_pkg::OP_FAULT, 6'd0, 32'h0, 32'h0);
    send_event(fcdl_pkg::OP_FAULT, 6'd0, 32'h1, 32'h2);
    send_event(fcdl_pkg::OP_FAULT, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(fcdl_pkg::OP_FAULT, 6'd0, $urandom, $urandom);
    send_event(fcdl_pkg::OP_OK, 6'd0, $urandom, $urandom);
    send_event(fcdl_pkg::OP_OK, 6'd0, $urandom, $urandom);
    send_event(fcdl_pkg::OP_OK, 6'd0, 32'h0, 32'hFFFF_FFFF);
    // reset right after a logged ok is filtered
    send_event(fcdl_pkg::OP_RESET, 6'd0, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd1, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd1, $urandom, $urandom);
    send_event(fcdl_pkg::OP_RESET, 6'd1, $urandom, $urandom);
    send_event(fcdl_pkg::OP_RESET, 6'd1, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd1, $urandom, $urandom);
    send_event(OP_UNUSED, 6'd1, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd5, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd6, $urandom, $urandom);
    send_event(fcdl_pkg::OP_OK, 6'd6, $urandom, $urandom);
    send_event(fcdl_pkg::OP_RESET, 6'd6, $urandom, $urandom);
    send_event(fcdl_pkg::OP_OK, 6'd32, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd63, 32'hFFFF_FFFF, 32'h0);
    send_event(fcdl_pkg::OP_OK, 6'd2, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd2, $urandom, $urandom);
    send_event(fcdl_pkg::OP_FAULT, 6'd2, $urandom, $urandom);
    send_event(fcdl_pkg::OP_OK, 6'd2, $urandom, $urandom);
    wait_idle();

    // everything enabled and recorded, widest cap
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, rand_thr_word(),
                 rand_thr_word(), rand_thr_word(), rand_thr_word(), 8'd255);
    random_events(200, 6);
    wait_idle();

    // all channels disabled, no records allowed
    program_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0, 64'h0, 64'h0, 8'd0);
    random_events(60, 4);
    wait_idle();

    // all channels reserved, highest thresholds
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1, '1,
                 fcdl_pkg::LOG_CAP_RESET);
    random_events(20, 4);
    wait_idle();

    // drive channel 31 through its largest threshold and past it
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0, 64'h0,
                 64'hFF00_0000_0000_0000, 8'd255);
    for (int k = 0; k < 258; k++) begin
      send_event(fcdl_pkg::OP_FAULT, 6'd31, $urandom, $urandom);
      maybe_idle(8);
    end
    repeat (3) send_event(fcdl_pkg::OP_OK, 6'd31, $urandom, $urandom);
    send_event(fcdl_pkg::OP_RESET, 6'd31, $urandom, $urandom);
    wait_idle();

    // random settings; the last phase runs without idling
    for (int p = 0; p < 6; p++) begin
      program_regs($urandom | $urandom,
                   ($urandom_range(0, 2) == 0) ? $urandom : 32'hFFFF_FFFF,
                   $urandom & $urandom & $urandom,
                   rand_thr_word(), rand_thr_word(), rand_thr_word(),
                   rand_thr_word(), rand_cap());
      random_events(130, (p == 5) ? 0 : ((p % 2 == 0) ? 5 : 12));
      wait_idle();
    end

    for (int w = 0; w < 200 && outstanding != 0; w++)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard limit well above the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
